FILE: hw/rtl/ulst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulst_pkg
// Shared widths, operation and status codes and the ring control type for the
// unsorted list table.
// ----------------------------------------------------------------------------
package ulst_pkg;

	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE       = 3'd1;
	localparam logic [OP_W-1:0] OP_RETRIEVE     = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR        = 3'd3;
	localparam logic [OP_W-1:0] OP_RESET_CURSOR = 3'd4;
	localparam logic [OP_W-1:0] OP_GET_NEXT     = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_END       = 2'd3;

	typedef struct packed {
		logic shift;
		logic replace;
	} ulst_ring_ctl_t;

endpackage

FILE: hw/rtl/ulst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulst_if
// Valid/ready channels for list commands and their results.
// ----------------------------------------------------------------------------
interface ulst_in_if import ulst_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [VAL_W-1:0] item_value;

	modport source (output valid, output op, output item_value, input ready);
	modport sink   (input valid, input op, input item_value, output ready);
endinterface

interface ulst_out_if import ulst_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [VAL_W-1:0]    item_out;
	logic [COUNT_W-1:0]  count;
	logic                full_res;

	modport source (output valid, output status, output found, output item_out,
		output count, output full_res, input ready);
	modport sink   (input valid, input status, input found, input item_out,
		input count, input full_res, output ready);
endinterface

FILE: hw/rtl/ulst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulst_cell
// One slot of the entry ring: holds an entry and takes its neighbour's entry
// on every shift.
// ----------------------------------------------------------------------------
module ulst_cell #(
	parameter int ITEM_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  shift,
	input  logic [ITEM_WIDTH-1:0] shift_in,
	output logic [ITEM_WIDTH-1:0] data
);

	logic [ITEM_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= shift_in;
		end
	end

	assign data = data_q;

endmodule

FILE: hw/rtl/ulst_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulst_seq
// Command sequencer: rotates the entry ring past the head cell, compares,
// captures and rewrites entries, and keeps count, cursor and the result.
// ----------------------------------------------------------------------------
module ulst_seq import ulst_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int ITEM_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ulst_in_if.sink               cmd,
	ulst_out_if.source            res,
	input  logic [ITEM_WIDTH-1:0] head,
	output ulst_ring_ctl_t        ring,
	output logic [ITEM_WIDTH-1:0] repl_data
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      cursor_q;
	logic                  out_valid_q;

	logic [OP_W-1:0]       op_q;
	logic [ITEM_WIDTH-1:0] key_q;
	logic [IDX_W-1:0]      step_q;
	logic                  pass_q;
	logic                  hit_q;
	logic                  err_q;
	logic [IDX_W-1:0]      loc_q;
	logic [ITEM_WIDTH-1:0] last_q;
	logic [ITEM_WIDTH-1:0] res_item_q;

	logic [STATUS_W-1:0]   status_q;
	logic                  found_q;
	logic [VAL_W-1:0]      item_q;
	logic [COUNT_W-1:0]    count_out_q;
	logic                  full_q;

	logic [ITEM_WIDTH-1:0] key_in;
	logic [VAL_W-1:0]      item_ext;
	logic [CNT_W-1:0]      kx;
	logic                  in_list;
	logic                  is_last;
	logic                  searching;
	logic                  hit_now;
	logic                  accept;
	logic                  fin_fire;
	logic                  accept_err;

	logic [STATUS_W-1:0]   status_d;
	logic                  found_d;
	logic                  use_item_d;
	logic [CNT_W-1:0]      count_d;
	logic [CNT_W-1:0]      cursor_d;

	if (ITEM_WIDTH >= VAL_W) begin : g_wide
		assign key_in   = ITEM_WIDTH'(cmd.item_value);
		assign item_ext = res_item_q[VAL_W-1:0];
	end else begin : g_narrow
		assign key_in   = cmd.item_value[ITEM_WIDTH-1:0];
		assign item_ext = VAL_W'(res_item_q);
	end

	assign accept   = cmd.valid && cmd.ready;
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || res.ready);

	// logical index of the entry now in the head cell
	assign kx        = CNT_W'(step_q);
	assign in_list   = kx < count_q;
	assign is_last   = in_list && (kx == count_q - CNT_W'(1));
	assign searching = (op_q == OP_DELETE || op_q == OP_RETRIEVE) && !pass_q;
	assign hit_now   = (state_q == S_SCAN) && searching && in_list && !hit_q
		&& (head == key_q);

	assign ring.shift   = (state_q == S_SCAN);
	assign ring.replace = (state_q == S_SCAN) &&
		((op_q == OP_INSERT && kx == count_q) ||
		 (op_q == OP_DELETE && pass_q && step_q == loc_q));
	// delete fills the hole with the last entry
	assign repl_data = (op_q == OP_INSERT) ? key_q : last_q;

	always_comb begin
		accept_err = 1'b0;
		if (cmd.op == OP_INSERT) begin
			accept_err = (count_q == CAP_CNT);
		end else if (cmd.op == OP_GET_NEXT) begin
			accept_err = !(cursor_q < count_q);
		end
	end

	always_comb begin
		status_d   = ST_OK;
		found_d    = 1'b0;
		use_item_d = 1'b0;
		count_d    = count_q;
		cursor_d   = cursor_q;
		unique case (op_q)
			OP_INSERT: begin
				if (err_q) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (hit_q) begin
					found_d = 1'b1;
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_RETRIEVE: begin
				if (hit_q) begin
					found_d    = 1'b1;
					use_item_d = 1'b1;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			OP_RESET_CURSOR: begin
				cursor_d = '0;
			end
			OP_GET_NEXT: begin
				if (err_q) begin
					status_d = ST_END;
				end else begin
					use_item_d = 1'b1;
					cursor_d   = cursor_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
				count_q     <= count_d;
				cursor_q    <= cursor_d;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((cmd.op == OP_INSERT || cmd.op == OP_GET_NEXT) && accept_err) begin
							state_q <= S_FIN;
						end else if (cmd.op == OP_INSERT || cmd.op == OP_DELETE ||
							cmd.op == OP_RETRIEVE || cmd.op == OP_GET_NEXT) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					// delete with a match goes round a second time to rewrite
					if (step_q == LAST_STEP &&
						!(op_q == OP_DELETE && !pass_q && (hit_q || hit_now))) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= cmd.op;
			key_q      <= key_in;
			step_q     <= '0;
			pass_q     <= 1'b0;
			hit_q      <= 1'b0;
			err_q      <= accept_err;
			res_item_q <= '0;
		end else if (state_q == S_SCAN) begin
			step_q <= (step_q == LAST_STEP) ? '0 : step_q + IDX_W'(1);
			if (hit_now) begin
				hit_q <= 1'b1;
				loc_q <= step_q;
				if (op_q == OP_RETRIEVE) begin
					res_item_q <= head;
				end
			end
			if (op_q == OP_DELETE && !pass_q && is_last) begin
				last_q <= head;
			end
			if (op_q == OP_GET_NEXT && kx == cursor_q) begin
				res_item_q <= head;
			end
			if (step_q == LAST_STEP && op_q == OP_DELETE && !pass_q && (hit_q || hit_now)) begin
				pass_q <= 1'b1;
			end
		end
		if (fin_fire) begin
			status_q    <= status_d;
			found_q     <= found_d;
			item_q      <= use_item_d ? item_ext : '0;
			count_out_q <= COUNT_W'(count_d);
			full_q      <= (count_d == CAP_CNT);
		end
	end

	assign cmd.ready    = (state_q == S_IDLE);
	assign res.valid    = out_valid_q;
	assign res.status   = status_q;
	assign res.found    = found_q;
	assign res.item_out = item_q;
	assign res.count    = count_out_q;
	assign res.full_res = full_q;

endmodule

FILE: hw/rtl/unsorted_list_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_list_table_core
// Unsorted list of up to CAPACITY entries with insert, delete, retrieve,
// clear and cursor walk, one result per command.
// ----------------------------------------------------------------------------
// The entries sit in a ring of CAPACITY cells that rotates one place a cycle
// past a single head cell, where the compare, capture and rewrite happen; a
// command that turns the ring turns it a whole revolution so the entries end
// where they began. Clear, reset cursor, unused codes, insert into a full list
// and get next past the end go straight to the finish state without turning
// the ring; insert, retrieve, get next and a delete that finds nothing turn it
// once; a delete that matches turns it twice, the second revolution moving the
// last entry into the hole.
// The next command is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module unsorted_list_table_core import ulst_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int ITEM_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ulst_in_if.sink    cmd,
	ulst_out_if.source res
);

	ulst_ring_ctl_t        ring;
	logic [ITEM_WIDTH-1:0] repl_data;
	logic [ITEM_WIDTH-1:0] tail_in;
	logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];

	ulst_seq #(
		.CAPACITY   (CAPACITY),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.head      (cell_data[0]),
		.ring      (ring),
		.repl_data (repl_data)
	);

	// head entry wraps to the tail unless it is being rewritten
	assign tail_in = ring.replace ? repl_data : cell_data[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_tail
			ulst_cell #(.ITEM_WIDTH(ITEM_WIDTH)) u_cell (
				.clk      (clk),
				.shift    (ring.shift),
				.shift_in (tail_in),
				.data     (cell_data[i])
			);
		end else begin : g_body
			ulst_cell #(.ITEM_WIDTH(ITEM_WIDTH)) u_cell (
				.clk      (clk),
				.shift    (ring.shift),
				.shift_in (cell_data[i+1]),
				.data     (cell_data[i])
			);
		end
	end

	// no command is taken while the ring is turning
	a_no_accept_while_shift: assert property (@(posedge clk) disable iff (!arst_n)
		ring.shift |-> !cmd.ready)
		else $error("command taken while the ring rotates");

	a_replace_needs_shift: assert property (@(posedge clk) disable iff (!arst_n)
		ring.replace |-> ring.shift)
		else $error("entry rewrite without rotation");

	a_found_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.found) |-> (res.status == ST_OK))
		else $error("match reported with an error status");

	a_full_reject_flags_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_FULL) |-> res.full_res)
		else $error("full rejection while list not full");

endmodule

FILE: tb/tb_unsorted_list_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unsorted_list_table_core
// Drives list commands through the valid/ready channels with random gaps and
// output stalls, predicts every result from a behavioural copy of the list
// and compares each returned result field by field against the prediction.
// ----------------------------------------------------------------------------
module tb_unsorted_list_table_core;
	import ulst_pkg::*;

	localparam int LIST_DEPTH   = 16;
	localparam int ITEM_COUNT   = 1200;
	localparam int STALL_LIMIT  = 2000;
	localparam int REPORT_LIMIT = 10;

	// op codes the block treats as no operation
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [VAL_W-1:0]    item;
		logic [COUNT_W-1:0]  count;
		logic                full;
	} list_result_t;

	class list_scoreboard;
		logic [VAL_W-1:0] slots [LIST_DEPTH];
		int unsigned      used;
		int unsigned      cursor;
		list_result_t     awaited [$];
		int               mismatches;
		int               checked;
		int               op_seen [8];
		int               full_rejects;
		int               misses;
		int               end_hits;
		int               peak_used;

		function int locate(logic [VAL_W-1:0] v);
			for (int i = 0; i < used; i++)
				if (slots[i] == v)
					return i;
			return -1;
		endfunction

		function void note_command(logic [OP_W-1:0] op, logic [VAL_W-1:0] v);
			list_result_t r;
			int           loc;
			r.status = ST_OK;
			r.found  = 1'b0;
			r.item   = '0;
			op_seen[op]++;
			case (op)
				OP_INSERT: begin
					if (used >= LIST_DEPTH) begin
						r.status = ST_FULL;
						full_rejects++;
					end else begin
						slots[used] = v;
						used++;
					end
				end
				OP_DELETE: begin
					loc = locate(v);
					if (loc < 0) begin
						r.status = ST_NOT_FOUND;
						misses++;
					end else begin
						// hole is filled from the tail
						slots[loc] = slots[used-1];
						used--;
						r.found = 1'b1;
					end
				end
				OP_RETRIEVE: begin
					loc = locate(v);
					if (loc < 0) begin
						r.status = ST_NOT_FOUND;
						misses++;
					end else begin
						r.found = 1'b1;
						r.item  = slots[loc];
					end
				end
				OP_CLEAR: used = 0;
				OP_RESET_CURSOR: cursor = 0;
				OP_GET_NEXT: begin
					// cursor may sit beyond the count after a clear or delete
					if (cursor < used) begin
						r.item = slots[cursor];
						cursor++;
					end else begin
						r.status = ST_END;
						end_hits++;
					end
				end
				default: ;
			endcase
			if (used > peak_used)
				peak_used = used;
			r.count = used[COUNT_W-1:0];
			r.full  = (used == LIST_DEPTH);
			awaited.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t exp_r;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("[%0t] result with nothing awaited: %s%0d %s%0d %s%h %s%0d %s%0d",
						$realtime, "st=", got.status, "fd=", got.found, "it=", got.item,
						"cnt=", got.count, "fl=", got.full);
				return;
			end
			exp_r = awaited.pop_front();
			if (got.status !== exp_r.status || got.found !== exp_r.found ||
				got.item !== exp_r.item || got.count !== exp_r.count ||
				got.full !== exp_r.full) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("[%0t] mismatch: exp st=%0d fd=%0d it=%h cnt=%0d fl=%0d",
						$realtime, exp_r.status, exp_r.found, exp_r.item, exp_r.count,
						exp_r.full);
					$display("[%0t]           got st=%0d fd=%0d it=%h cnt=%0d fl=%0d",
						$realtime, got.status, got.found, got.item, got.count, got.full);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   sent;
	int   idle_cycles;

	list_scoreboard sb = new;

	ulst_in_if  cmd ();
	ulst_out_if res ();

	unsorted_list_table_core #(
		.CAPACITY   (LIST_DEPTH),
		.ITEM_WIDTH (VAL_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.res    (res.source)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one command transfer; valid stays high when there is no gap
	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.op         <= op;
		cmd.item_value <= v;
		do @(posedge clk); while (!cmd.ready);
		sb.note_command(op, v);
		sent++;
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return $urandom_range(1, 7);
			default: return $urandom;
		endcase
	endfunction

	// mostly reuse held entries so searches and deletes hit
	function automatic logic [VAL_W-1:0] pick_target();
		if (sb.used > 0 && $urandom_range(0, 9) < 7)
			return sb.slots[$urandom_range(0, sb.used - 1)];
		return pick_value();
	endfunction

	// result side: random stall before each transfer
	initial begin
		int stall;
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	always @(posedge clk) begin : result_monitor
		list_result_t got;
		if (arst_n && res.valid && res.ready) begin
			got.status = res.status;
			got.found  = res.found;
			got.item   = res.item_out;
			got.count  = res.count;
			got.full   = res.full_res;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIMIT, sb.awaited.size());
			$display("Some tests failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int kind;
		int n;
		bit first_fill;
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.op         = OP_INSERT;
		cmd.item_value = '0;
		calm           = 1'b0;
		sent           = 0;
		first_fill     = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, extremes, duplicates, walk past end, spare codes
		send_cmd(OP_GET_NEXT, '0);
		send_cmd(OP_RETRIEVE, 32'h5);
		send_cmd(OP_DELETE, 32'h5);
		send_cmd(OP_INSERT, '0);
		send_cmd(OP_INSERT, '1);
		send_cmd(OP_INSERT, '1);
		send_cmd(OP_INSERT, 32'h1234_5678);
		send_cmd(OP_RETRIEVE, '1);
		send_cmd(OP_RETRIEVE, 32'h1234_5679);
		repeat (5) send_cmd(OP_GET_NEXT, '1);
		// delete with the cursor active leaves the cursor beyond the count
		send_cmd(OP_DELETE, '0);
		send_cmd(OP_GET_NEXT, '0);
		send_cmd(OP_RESET_CURSOR, '1);
		send_cmd(OP_GET_NEXT, '0);
		send_cmd(OP_SPARE_A, '1);
		send_cmd(OP_SPARE_B, 32'hA5A5_5A5A);
		send_cmd(OP_CLEAR, '1);
		send_cmd(OP_GET_NEXT, '0);
		send_cmd(OP_RESET_CURSOR, '0);
		drain();

		while (sent < ITEM_COUNT) begin
			kind = first_fill ? 0 : $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					n = first_fill ? LIST_DEPTH + 2 : $urandom_range(1, LIST_DEPTH + 2);
					first_fill = 1'b0;
					repeat (n) send_cmd(OP_INSERT, pick_value());
				end
				3, 4: begin
					send_cmd(OP_RESET_CURSOR, $urandom);
					n = sb.used + $urandom_range(0, 2);
					repeat (n) send_cmd(OP_GET_NEXT, $urandom);
				end
				5, 6: begin
					n = $urandom_range(2, 8);
					repeat (n)
						send_cmd($urandom_range(0, 1) ? OP_DELETE : OP_RETRIEVE, pick_target());
				end
				7: begin
					send_cmd(OP_CLEAR, $urandom);
					if ($urandom_range(0, 1))
						send_cmd(OP_GET_NEXT, $urandom);
				end
				8: begin
					n = $urandom_range(1, 6);
					repeat (n) send_cmd(OP_W'($urandom_range(0, 7)), pick_target());
				end
				default: begin
					drain();
					calm = ($urandom_range(0, 2) == 0);
				end
			endcase
		end

		cmd.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (2 * LIST_DEPTH + 8) @(posedge clk);

		$display("ran %0d commands: %0d insert, %0d delete, %0d retrieve, %0d clear, %0d walk",
			sent, sb.op_seen[OP_INSERT], sb.op_seen[OP_DELETE], sb.op_seen[OP_RETRIEVE],
			sb.op_seen[OP_CLEAR], sb.op_seen[OP_RESET_CURSOR] + sb.op_seen[OP_GET_NEXT]);
		$display("%0d results checked, full rejects %0d, misses %0d, end of list %0d, %s%0d, %s%0d",
			sb.checked, sb.full_rejects, sb.misses, sb.end_hits,
			"peak fill ", sb.peak_used, "mismatches ", sb.mismatches);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/ulst_pkg.sv
hw/rtl/ulst_if.sv
hw/rtl/ulst_cell.sv
hw/rtl/ulst_seq.sv
hw/rtl/unsorted_list_table_core.sv
tb/tb_unsorted_list_table_core.sv
